// ----- design/rarb_pkg.sv -----
package rarb_pkg;

   // Field widths of the request and response transactions
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 16;
   localparam int unsigned STATUS_W = 3;

   // Width for the free-space arithmetic: holds any depth up to 65536
   localparam int unsigned CALC_W = 17;

   // Opcodes
   localparam logic OP_BYTE  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] ST_STAGED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_COMMITTED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DISCARDED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DRAINED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd5;

   // Outcome of one accepted transaction, from the controller to the top
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                record_done;
      logic                rd_pending;
   } result_type;

endpackage

// ----- design/rarb_ring_mem.sv -----
module rarb_ring_mem #(
   parameter int unsigned RING_DEPTH = 4096,
   parameter int unsigned ADDR_W     = 12
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [rarb_pkg::BYTE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [rarb_pkg::BYTE_W-1:0] rd_data
);

   logic [rarb_pkg::BYTE_W-1:0] ring_ff [RING_DEPTH];
   logic [rarb_pkg::BYTE_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ring_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/rarb_ctrl.sv -----
module rarb_ctrl #(
   parameter int unsigned RING_DEPTH = 4096,
   parameter int unsigned ADDR_W     = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           fire,
   input  logic                           opcode,
   input  logic [rarb_pkg::BYTE_W-1:0]    data_byte,
   input  logic                           record_start,
   input  logic [rarb_pkg::LEN_W-1:0]     record_length,
   output rarb_pkg::result_type           result,
   output logic                           wr_en,
   output logic [ADDR_W-1:0]              wr_addr,
   output logic [rarb_pkg::BYTE_W-1:0]    wr_data,
   output logic                           rd_en,
   output logic [ADDR_W-1:0]              rd_addr
);

   localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(RING_DEPTH - 1);
   localparam logic [rarb_pkg::CALC_W-1:0] DEPTH_C = rarb_pkg::CALC_W'(RING_DEPTH);
   localparam logic [rarb_pkg::CALC_W-1:0] ONE_C   = rarb_pkg::CALC_W'(1);

   logic [ADDR_W-1:0]          write_ff, write_in;
   logic [ADDR_W-1:0]          read_ff, read_in;
   logic [ADDR_W-1:0]          staged_ff, staged_in;
   logic [rarb_pkg::LEN_W-1:0] left_ff, left_in;
   logic                       drop_ff, drop_in;

   logic [rarb_pkg::CALC_W-1:0] w_ext, r_ext, used, free_bytes;
   logic                        fits;
   logic [rarb_pkg::LEN_W-1:0]  left_eff, left_dec;
   logic                        drop_eff;
   logic [ADDR_W-1:0]           stage_eff, stage_next, read_next;

   // Occupancy and free space of the committed ring
   always_comb begin
      w_ext = rarb_pkg::CALC_W'(write_ff);
      r_ext = rarb_pkg::CALC_W'(read_ff);
      if (write_ff >= read_ff) begin
         used = w_ext - r_ext;
      end else begin
         used = w_ext + DEPTH_C - r_ext;
      end
      free_bytes = DEPTH_C - ONE_C - used;
      fits = rarb_pkg::CALC_W'(record_length) <= free_bytes;
   end

   // Record state as seen by this transaction, after a start byte opens it
   always_comb begin
      left_eff  = left_ff;
      drop_eff  = drop_ff;
      stage_eff = staged_ff;
      if (record_start) begin
         left_eff = record_length;
         drop_eff = (record_length != '0) && !fits;
         if ((record_length != '0) && fits) begin
            stage_eff = write_ff;
         end
      end
      left_dec   = left_eff - rarb_pkg::LEN_W'(1);
      stage_next = (stage_eff == LAST_POS) ? '0 : stage_eff + ADDR_W'(1);
      read_next  = (read_ff == LAST_POS) ? '0 : read_ff + ADDR_W'(1);
   end

   // Decide the outcome and the next state
   always_comb begin
      write_in           = write_ff;
      read_in            = read_ff;
      staged_in          = staged_ff;
      left_in            = left_ff;
      drop_in            = drop_ff;
      result.status      = rarb_pkg::ST_OUTSIDE;
      result.record_done = 1'b0;
      result.rd_pending  = 1'b0;
      wr_en              = 1'b0;
      rd_en              = 1'b0;
      if (opcode == rarb_pkg::OP_DRAIN) begin
         if (read_ff == write_ff) begin
            result.status = rarb_pkg::ST_EMPTY;
         end else begin
            result.status     = rarb_pkg::ST_DRAINED;
            result.rd_pending = 1'b1;
            rd_en             = fire;
            read_in           = read_next;
         end
      end else begin
         staged_in = stage_eff;
         left_in   = left_eff;
         drop_in   = drop_eff;
         if (left_eff == '0) begin
            result.status = rarb_pkg::ST_OUTSIDE;
         end else if (drop_eff) begin
            left_in       = left_dec;
            result.status = rarb_pkg::ST_DISCARDED;
            if (left_dec == '0) begin
               drop_in            = 1'b0;
               result.record_done = 1'b1;
            end
         end else begin
            wr_en     = fire;
            staged_in = stage_next;
            left_in   = left_dec;
            if (left_dec == '0) begin
               write_in           = stage_next;
               result.status      = rarb_pkg::ST_COMMITTED;
               result.record_done = 1'b1;
            end else begin
               result.status = rarb_pkg::ST_STAGED;
            end
         end
      end
   end

   assign wr_addr = stage_eff;
   assign wr_data = data_byte;
   assign rd_addr = read_ff;

   // Advance the offsets on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         write_ff  <= '0;
         read_ff   <= '0;
         staged_ff <= '0;
         left_ff   <= '0;
         drop_ff   <= 1'b0;
      end else if (fire) begin
         write_ff  <= write_in;
         read_ff   <= read_in;
         staged_ff <= staged_in;
         left_ff   <= left_in;
         drop_ff   <= drop_in;
      end
   end

   // A commit lands the write offset on the staged end of the record
   assert property (@(posedge clock) disable iff (reset)
      fire && (result.status == rarb_pkg::ST_COMMITTED) |=> (write_ff == staged_ff))
      else $error("write offset does not match staged end after commit");

   // A discarding record never writes the ring
   assert property (@(posedge clock) disable iff (reset)
      fire && (result.status == rarb_pkg::ST_DISCARDED) |-> !wr_en)
      else $error("ring written while discarding a record");

   // An empty drain leaves the ring untouched
   assert property (@(posedge clock) disable iff (reset)
      fire && (result.status == rarb_pkg::ST_EMPTY) |-> !rd_en && !wr_en)
      else $error("ring accessed on an empty drain");

endmodule

// ----- design/record_atomic_ring_buffer_top.sv -----
// Record-atomic byte ring buffer. Holds up to RING_DEPTH-1 committed bytes;
// a record is written one byte per request transaction, its first byte
// carrying the total length, and becomes visible to drains only when its
// last byte arrives. A record longer than the free space at its first byte
// is discarded whole. Each request gives exactly one response. A drain that
// pops a byte holds off the next request until the byte is read, since the
// ring memory's registered read port delivers the byte in the cycle after
// the address. The ring store needs no clearing after reset: only committed
// positions are ever read. A new request can be taken in the same cycle
// that the previous response is taken, but not while a ring read is in flight.
module record_atomic_ring_buffer_top #(
   parameter int unsigned RING_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] data_byte, [23:8] record_length
   input  logic [1:0]  req_tuser,   // [0] opcode, [1] record_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] read_data
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast    // record_done
);

   localparam int unsigned ADDR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

   logic                          fire;
   rarb_pkg::result_type          result;
   logic                          wr_en, rd_en;
   logic [ADDR_W-1:0]             wr_addr, rd_addr;
   logic [rarb_pkg::BYTE_W-1:0]   wr_data, rd_data;

   logic                          pending_ff, pending_in;
   logic                          valid_ff, valid_in;
   logic [rarb_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [rarb_pkg::BYTE_W-1:0]   data_ff, data_in;
   logic                          done_ff, done_in;
   logic                          load;

   // Accept when no read is in flight and the response slot frees up
   assign req_tready = !pending_ff && (!valid_ff || rsp_tready);
   assign fire       = req_tvalid && req_tready;

   rarb_ctrl #(
      .RING_DEPTH (RING_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .opcode        (req_tuser[0]),
      .data_byte     (req_tdata[7:0]),
      .record_start  (req_tuser[1]),
      .record_length (req_tdata[23:8]),
      .result        (result),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr)
   );

   rarb_ring_mem #(
      .RING_DEPTH (RING_DEPTH),
      .ADDR_W     (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Load the response register from the decision or from the memory read
   always_comb begin
      pending_in = pending_ff;
      load       = 1'b0;
      status_in  = status_ff;
      data_in    = data_ff;
      done_in    = done_ff;
      if (pending_ff) begin
         pending_in = 1'b0;
         load       = 1'b1;
         status_in  = rarb_pkg::ST_DRAINED;
         data_in    = rd_data;
         done_in    = 1'b0;
      end else if (fire) begin
         if (result.rd_pending) begin
            pending_in = 1'b1;
         end else begin
            load      = 1'b1;
            status_in = result.status;
            data_in   = '0;
            done_in   = result.record_done;
         end
      end
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         valid_ff   <= valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         data_ff   <= data_in;
         done_ff   <= done_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = done_ff;

   // A popping drain leaves the response slot empty while the read is in flight
   assert property (@(posedge clock) disable iff (reset)
      fire && result.rd_pending |=> pending_ff && !rsp_tvalid)
      else $error("response slot busy during ring read");

   // The read in flight turns into a drained-byte response next cycle
   assert property (@(posedge clock) disable iff (reset)
      pending_ff |=> rsp_tvalid && (rsp_tuser == rarb_pkg::ST_DRAINED) && !pending_ff)
      else $error("ring read did not produce a drained response");

   // End of record is flagged only on commit or discard
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         (rsp_tuser == rarb_pkg::ST_COMMITTED) || (rsp_tuser == rarb_pkg::ST_DISCARDED))
      else $error("record end flagged on a non-record response");

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD  = 12;
   localparam int RING_SIZE   = 4096;
   localparam int PTR_W       = $clog2(RING_SIZE);
   localparam int PHASE_ITEMS = 570;
   localparam int TAIL_CYCLES = 16;
   localparam int CYCLE_LIMIT = 600000;

   // One request transaction, split into its fields
   typedef struct packed {
      logic                        opcode;
      logic [rarb_pkg::BYTE_W-1:0] data;
      logic                        start;
      logic [rarb_pkg::LEN_W-1:0]  length;
   } ring_req_type;

   // One response transaction
   typedef struct packed {
      logic [rarb_pkg::STATUS_W-1:0] status;
      logic [rarb_pkg::BYTE_W-1:0]   rdata;
      logic                          done;
   } ring_rsp_type;

   // Row of the directed stimulus table; want is used only when typed is set
   typedef struct {
      ring_req_type req;
      bit           typed;
      ring_rsp_type want;
   } dir_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [7:0] data_byte, [23:8] record_length
   logic [1:0]  req_tuser  = '0;   // [0] opcode, [1] record_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [7:0] read_data
   logic [2:0]  rsp_tuser;         // [2:0] status
   logic        rsp_tlast;

   // Shadow ring state
   logic [rarb_pkg::BYTE_W-1:0] ring_mem [RING_SIZE];
   logic [PTR_W-1:0]            wr_ptr     = '0;
   logic [PTR_W-1:0]            rd_ptr     = '0;
   logic [PTR_W-1:0]            stage_ptr  = '0;
   logic [rarb_pkg::LEN_W-1:0]  left_bytes = '0;
   logic                        discarding = 1'b0;

   ring_rsp_type pending_rsp_q [$];
   dir_row_type  dir_rows [$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int phase_items = 0;
   int sent_count = 0;
   int commit_count = 0;
   int discard_done_count = 0;
   int drained_count = 0;
   int empty_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   record_atomic_ring_buffer_top #(
      .RING_DEPTH(RING_SIZE)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_SIZE - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic int ring_free();
      int used;
      used = (int'(wr_ptr) + RING_SIZE - int'(rd_ptr)) % RING_SIZE;
      return RING_SIZE - 1 - used;
   endfunction

   // Apply one accepted transaction to the shadow ring and return its response
   function automatic ring_rsp_type ring_apply(ring_req_type r);
      ring_rsp_type o;
      o = '0;
      if (r.opcode == rarb_pkg::OP_DRAIN) begin
         if (rd_ptr == wr_ptr) begin
            o.status = rarb_pkg::ST_EMPTY;
         end else begin
            o.rdata  = ring_mem[rd_ptr];
            rd_ptr   = ring_next(rd_ptr);
            o.status = rarb_pkg::ST_DRAINED;
         end
      end else begin
         // A start always closes whatever record was open
         if (r.start) begin
            left_bytes = '0;
            discarding = 1'b0;
            if (r.length != '0) begin
               left_bytes = r.length;
               if (int'(r.length) > ring_free()) discarding = 1'b1;
               else stage_ptr = wr_ptr;
            end
         end
         if (left_bytes == '0) begin
            o.status = rarb_pkg::ST_OUTSIDE;
         end else if (discarding) begin
            left_bytes = left_bytes - 1'b1;
            o.status   = rarb_pkg::ST_DISCARDED;
            if (left_bytes == '0) begin
               discarding = 1'b0;
               o.done     = 1'b1;
            end
         end else begin
            ring_mem[stage_ptr] = r.data;
            stage_ptr  = ring_next(stage_ptr);
            left_bytes = left_bytes - 1'b1;
            if (left_bytes == '0) begin
               wr_ptr   = stage_ptr;
               o.status = rarb_pkg::ST_COMMITTED;
               o.done   = 1'b1;
            end else begin
               o.status = rarb_pkg::ST_STAGED;
            end
         end
      end
      return o;
   endfunction

   function automatic ring_req_type mk_req(logic op, logic [rarb_pkg::BYTE_W-1:0] d,
                                           logic s, logic [rarb_pkg::LEN_W-1:0] len);
      ring_req_type r;
      r.opcode = op;
      r.data   = d;
      r.start  = s;
      r.length = len;
      return r;
   endfunction

   function automatic dir_row_type dir_pred(logic op, logic [rarb_pkg::BYTE_W-1:0] d,
                                            logic s, logic [rarb_pkg::LEN_W-1:0] len);
      dir_row_type row;
      row.req   = mk_req(op, d, s, len);
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   function automatic dir_row_type dir_typed(logic op, logic [rarb_pkg::BYTE_W-1:0] d,
                                             logic s, logic [rarb_pkg::LEN_W-1:0] len,
                                             logic [rarb_pkg::STATUS_W-1:0] st,
                                             logic [rarb_pkg::BYTE_W-1:0] rd, logic dn);
      dir_row_type row;
      row.req         = mk_req(op, d, s, len);
      row.typed       = 1'b1;
      row.want.status = st;
      row.want.rdata  = rd;
      row.want.done   = dn;
      return row;
   endfunction

   // Drive one request, hold it until accepted, then record its expected response.
   // Call and return just after a falling edge.
   task automatic send_item(ring_req_type r, bit typed, ring_rsp_type want);
      ring_rsp_type pred;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {r.length, r.data};
      req_tuser  <= {r.start, r.opcode};
      do @(posedge clock); while (!req_tready);
      pred = ring_apply(r);
      pending_rsp_q.push_back(typed ? want : pred);
      sent_count++;
      phase_items++;
      case (pred.status)
         rarb_pkg::ST_COMMITTED: commit_count++;
         rarb_pkg::ST_DRAINED:   drained_count++;
         rarb_pkg::ST_EMPTY:     empty_count++;
         rarb_pkg::ST_DISCARDED: if (pred.done) discard_done_count++;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic send_drain();
      send_item(mk_req(rarb_pkg::OP_DRAIN, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535))),
                1'b0, '0);
   endtask

   // Send the first nbytes of a record of length len, with drains mixed in
   task automatic send_record(int unsigned len, int unsigned nbytes, int drain_pct);
      for (int unsigned i = 0; i < nbytes; i++) begin
         if (i > 0 && $urandom_range(0, 99) < drain_pct) send_drain();
         send_item(mk_req(rarb_pkg::OP_BYTE, 8'($urandom_range(0, 255)), i == 0,
                          (i == 0) ? 16'(len) : 16'($urandom_range(0, 65535))),
                   1'b0, '0);
      end
   endtask

   // One random episode: mostly well-formed records and drain bursts, some noise
   task automatic random_episode();
      int unsigned pick;
      int unsigned sz;
      int unsigned len;
      int unsigned nbytes;
      int          fr;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         sz = $urandom_range(0, 99);
         fr = ring_free();
         if (sz < 60) len = $urandom_range(1, 8);
         else if (sz < 85) len = $urandom_range(9, 64);
         else if (sz < 95) len = $urandom_range(65, 300);
         else len = (fr < 65535) ? $urandom_range(fr + 1, 65535) : 65535;
         nbytes = len;
         if (int'(len) > fr) begin
            if (len > 8) nbytes = $urandom_range(1, 6);
         end else if ($urandom_range(0, 99) < 10) begin
            nbytes = $urandom_range(1, len);
         end
         send_record(len, nbytes, 15);
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 12)) send_drain();
      end else if (pick < 93) begin
         send_item(mk_req(rarb_pkg::OP_BYTE, 8'($urandom_range(0, 255)), 1'b0,
                          16'($urandom_range(0, 65535))), 1'b0, '0);
      end else begin
         send_item(mk_req(rarb_pkg::OP_BYTE, 8'($urandom_range(0, 255)), 1'b1, '0),
                   1'b0, '0);
      end
   endtask

   // Stall the response side at random
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
   end

   // Compare each accepted response against the oldest expectation
   always @(posedge clock) begin : check_rsp
      ring_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp_q.size() == 0) begin
            $error("unexpected response: status %0d, read_data 0x%02h, record_done %0d",
                   rsp_tuser, rsp_tdata, rsp_tlast);
            mismatch_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata !== want.rdata) begin
               $error("read_data mismatch: expected 0x%02h, actual 0x%02h",
                      want.rdata, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tlast !== want.done) begin
               $error("record_done mismatch: expected %0d, actual %0d", want.done, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      // Directed rows: field extremes, every status, and the corner cases
      dir_rows.push_back(dir_typed(rarb_pkg::OP_DRAIN, 8'hFF, 1'b1, 16'hFFFF,
                                   rarb_pkg::ST_EMPTY, 8'h00, 1'b0));
      dir_rows.push_back(dir_typed(rarb_pkg::OP_BYTE, 8'h00, 1'b0, 16'h0000,
                                   rarb_pkg::ST_OUTSIDE, 8'h00, 1'b0));
      dir_rows.push_back(dir_typed(rarb_pkg::OP_BYTE, 8'hFF, 1'b1, 16'h0000,
                                   rarb_pkg::ST_OUTSIDE, 8'h00, 1'b0));
      dir_rows.push_back(dir_typed(rarb_pkg::OP_BYTE, 8'h00, 1'b1, 16'hFFFF,
                                   rarb_pkg::ST_DISCARDED, 8'h00, 1'b0));
      dir_rows.push_back(dir_typed(rarb_pkg::OP_BYTE, 8'h12, 1'b0, 16'hFFFF,
                                   rarb_pkg::ST_DISCARDED, 8'h00, 1'b0));
      dir_rows.push_back(dir_typed(rarb_pkg::OP_BYTE, 8'hA5, 1'b1, 16'd1,
                                   rarb_pkg::ST_COMMITTED, 8'h00, 1'b1));
      dir_rows.push_back(dir_typed(rarb_pkg::OP_DRAIN, 8'h00, 1'b0, 16'h0000,
                                   rarb_pkg::ST_DRAINED, 8'hA5, 1'b0));
      dir_rows.push_back(dir_typed(rarb_pkg::OP_DRAIN, 8'h00, 1'b0, 16'h0000,
                                   rarb_pkg::ST_EMPTY, 8'h00, 1'b0));
      dir_rows.push_back(dir_typed(rarb_pkg::OP_BYTE, 8'h00, 1'b1, 16'd3,
                                   rarb_pkg::ST_STAGED, 8'h00, 1'b0));
      dir_rows.push_back(dir_typed(rarb_pkg::OP_BYTE, 8'hFF, 1'b0, 16'h0000,
                                   rarb_pkg::ST_STAGED, 8'h00, 1'b0));
      // Staged bytes stay invisible to drains
      dir_rows.push_back(dir_typed(rarb_pkg::OP_DRAIN, 8'h00, 1'b0, 16'h0000,
                                   rarb_pkg::ST_EMPTY, 8'h00, 1'b0));
      // New start abandons the open record
      dir_rows.push_back(dir_pred(rarb_pkg::OP_BYTE, 8'h5A, 1'b1, 16'd2));
      dir_rows.push_back(dir_pred(rarb_pkg::OP_BYTE, 8'h3C, 1'b0, 16'h0000));
      dir_rows.push_back(dir_typed(rarb_pkg::OP_BYTE, 8'h77, 1'b0, 16'h0000,
                                   rarb_pkg::ST_OUTSIDE, 8'h00, 1'b0));
      dir_rows.push_back(dir_pred(rarb_pkg::OP_BYTE, 8'h11, 1'b1, 16'd4095));
      dir_rows.push_back(dir_typed(rarb_pkg::OP_BYTE, 8'h00, 1'b1, 16'h0000,
                                   rarb_pkg::ST_OUTSIDE, 8'h00, 1'b0));
      // A record exactly the size of the free space is staged
      dir_rows.push_back(dir_pred(rarb_pkg::OP_BYTE, 8'h00, 1'b1, 16'd4093));
      // One past the free space is dropped
      dir_rows.push_back(dir_pred(rarb_pkg::OP_BYTE, 8'h00, 1'b1, 16'd4094));
      dir_rows.push_back(dir_pred(rarb_pkg::OP_BYTE, 8'h01, 1'b1, 16'd3));
      // Drain during an open record
      dir_rows.push_back(dir_pred(rarb_pkg::OP_DRAIN, 8'h00, 1'b0, 16'h0000));
      dir_rows.push_back(dir_pred(rarb_pkg::OP_BYTE, 8'h02, 1'b0, 16'h0000));
      dir_rows.push_back(dir_pred(rarb_pkg::OP_BYTE, 8'h03, 1'b0, 16'h0000));
      dir_rows.push_back(dir_pred(rarb_pkg::OP_DRAIN, 8'h00, 1'b0, 16'h0000));
      dir_rows.push_back(dir_pred(rarb_pkg::OP_DRAIN, 8'h00, 1'b0, 16'h0000));
      dir_rows.push_back(dir_pred(rarb_pkg::OP_DRAIN, 8'h00, 1'b0, 16'h0000));
      dir_rows.push_back(dir_pred(rarb_pkg::OP_DRAIN, 8'h00, 1'b0, 16'h0000));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender idles lightly, receiver heavily
      tx_idle_pct = 25;
      rx_idle_pct = 64;
      foreach (dir_rows[i]) send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) random_episode();

      // Swap the idling sides
      tx_idle_pct = 64;
      rx_idle_pct = 25;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) random_episode();

      // Full rate on both sides
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) random_episode();

      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d records committed, %0d dropped whole,",
               sent_count, commit_count, discard_done_count);
      $display("%0d bytes drained, %0d empty drains, free-space edge hit on both sides.",
               drained_count, empty_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- record_atomic_ring_buffer_top.f -----
design/rarb_pkg.sv
design/rarb_ring_mem.sv
design/rarb_ctrl.sv
design/record_atomic_ring_buffer_top.sv
tb/sv/testbench.sv
